### rtl/core/sfl_pkg.sv
// ----------------------------------------------------------------------------
// sfl_pkg
// Types, constants and helpers shared by the segregated free-list pool.
// ----------------------------------------------------------------------------
package sfl_pkg;

  localparam int NUM_DESC    = 64;
  localparam int MAX_CLASSES = 8;
  localparam int SIZE_BITS   = 32;
  localparam int IDX_W       = $clog2(NUM_DESC);
  localparam int LINK_W      = IDX_W + 1;
  localparam int CLS_W       = $clog2(MAX_CLASSES);
  localparam int CCNT_W      = 4;
  localparam int LIMIT_W     = 16;
  localparam int QDEPTH      = 2;

  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(NUM_DESC);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_FIT  = 2'd1,
    ST_NOTFREE = 2'd2
  } status_t;

  typedef enum logic {
    CFG_FIRST_LIMIT = 1'b0,
    CFG_CLASS_COUNT = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]           op;
    logic [IDX_W-1:0]     descriptor_index;
    logic [SIZE_BITS-1:0] block_size;
    logic [SIZE_BITS-1:0] request_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [IDX_W-1:0]     granted_index;
    logic [SIZE_BITS-1:0] granted_size;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    op_t                  op;
    logic [IDX_W-1:0]     idx;
    logic [SIZE_BITS-1:0] size;
    logic [CLS_W-1:0]     cls;
    logic [CLS_W:0]       ncls;
  } cmd_t;

endpackage

### rtl/core/sfl_ram.sv
// ----------------------------------------------------------------------------
// sfl_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module sfl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/sfl_front.sv
// ----------------------------------------------------------------------------
// sfl_front
// Accepts items, works out the size class and queues classified commands.
// ----------------------------------------------------------------------------
module sfl_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sfl_pkg::in_item_t             in_data,
  input  logic [sfl_pkg::LIMIT_W-1:0]   first_limit,
  input  logic [sfl_pkg::CCNT_W-1:0]    class_count,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output sfl_pkg::cmd_t                 cmd
);
  import sfl_pkg::*;

  localparam int QW = $clog2(QDEPTH);

  // classification stage
  logic       s_valid_r;
  in_item_t   s_item_r;
  logic [CLS_W:0] ncls;
  logic [CLS_W-1:0] cls;
  logic [SIZE_BITS-1:0] key;
  logic [SIZE_BITS+MAX_CLASSES-1:0] lim;

  cmd_t       q_r [QDEPTH];
  logic [QW-1:0] wp_r, rp_r;
  logic [QW:0]   cnt_r;
  logic          q_full, push, pop;

  always_comb begin
    if (class_count == '0) ncls = (CLS_W+1)'(1);
    else if (32'(class_count) > MAX_CLASSES) ncls = (CLS_W+1)'(MAX_CLASSES);
    else ncls = (CLS_W+1)'(class_count);
  end

  assign key = (s_item_r.op == OP_GET) ? s_item_r.request_size : s_item_r.block_size;

  // independent compares against each doubled limit
  always_comb begin
    cls = '0;
    for (int i = 0; i < MAX_CLASSES - 1; i++) begin
      lim = (SIZE_BITS+MAX_CLASSES)'(first_limit) << i;
      if ((i + 1) < 32'(ncls) && (SIZE_BITS+MAX_CLASSES)'(key) > lim)
        cls = CLS_W'(i + 1);
    end
  end

  assign q_full   = (cnt_r == (QW+1)'(QDEPTH));
  assign push     = s_valid_r && !q_full;
  assign in_ready = !s_valid_r || push;
  assign pop      = cmd_valid && cmd_ready;
  assign cmd_valid = (cnt_r != '0);
  assign cmd      = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (in_ready) s_valid_r <= in_valid;
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
    if (in_ready && in_valid) s_item_r <= in_data;
    if (push) begin
      q_r[wp_r].op   <= op_t'(s_item_r.op);
      q_r[wp_r].idx  <= s_item_r.descriptor_index;
      q_r[wp_r].size <= key;
      q_r[wp_r].cls  <= cls;
      q_r[wp_r].ncls <= ncls;
    end
  end

endmodule

### rtl/core/sfl_back.sv
// ----------------------------------------------------------------------------
// sfl_back
// Executes add, remove and get against the linked lists in RAM.
// ----------------------------------------------------------------------------
module sfl_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sfl_pkg::cmd_t     cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output sfl_pkg::out_item_t out_data
);
  import sfl_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD_SLOT, S_UNLINK_A, S_UNLINK_B, S_UNLINK_C,
    S_PUSH_A, S_PUSH_B, S_GET_HEAD, S_GET_RD, S_GET_CHK, S_DONE
  } state_t;

  state_t state_r;
  cmd_t   c_r;
  logic [LINK_W-1:0] heads_r [MAX_CLASSES];
  logic [NUM_DESC-1:0] free_r;
  logic [LINK_W-1:0] nx_r, pv_r, p_r;
  logic [CLS_W:0]    gc_r;
  logic [IDX_W:0]    steps_r;
  logic [1:0]        st_r;
  logic [IDX_W-1:0]  gidx_r;
  logic [SIZE_BITS-1:0] gsize_r;
  logic              get_unlink_r;

  // link and size memories: one write and one read port each
  logic              nx_we, pv_we, sz_we;
  logic [IDX_W-1:0]  nx_wa, pv_wa, sz_wa, rd_a;
  logic [LINK_W-1:0] nx_wd, pv_wd, nx_rd, pv_rd;
  logic [SIZE_BITS-1:0] sz_rd;

  sfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_DESC)) u_next (
    .clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd), .raddr(rd_a), .rdata(nx_rd));
  sfl_ram #(.WIDTH(LINK_W), .DEPTH(NUM_DESC)) u_prev (
    .clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd), .raddr(rd_a), .rdata(pv_rd));
  sfl_ram #(.WIDTH(SIZE_BITS), .DEPTH(NUM_DESC)) u_size (
    .clk, .we(sz_we), .waddr(sz_wa), .wdata(c_r.size), .raddr(rd_a), .rdata(sz_rd));

  assign cmd_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);
  assign out_data  = '{status: st_r, granted_index: gidx_r, granted_size: gsize_r};

  always_comb begin
    nx_we = 1'b0; pv_we = 1'b0; sz_we = 1'b0;
    nx_wa = c_r.idx; pv_wa = c_r.idx; sz_wa = c_r.idx;
    nx_wd = NIL_LINK; pv_wd = NIL_LINK;
    rd_a  = (state_r == S_IDLE) ? cmd.idx : p_r[IDX_W-1:0];
    case (state_r)
      S_UNLINK_A: begin
        // next[prev] <= next
        nx_we = (pv_r != NIL_LINK);
        nx_wa = pv_r[IDX_W-1:0];
        nx_wd = nx_r;
        pv_we = (nx_r != NIL_LINK);
        pv_wa = nx_r[IDX_W-1:0];
        pv_wd = pv_r;
      end
      S_UNLINK_B: begin
        nx_we = 1'b1;
        pv_we = 1'b1;
        nx_wa = p_r[IDX_W-1:0];
        pv_wa = p_r[IDX_W-1:0];
      end
      S_PUSH_A: begin
        sz_we = 1'b1;
        nx_we = 1'b1;
        nx_wd = heads_r[c_r.cls];
        pv_we = 1'b1;
      end
      S_PUSH_B: begin
        pv_we = (heads_r[c_r.cls] != NIL_LINK);
        pv_wa = heads_r[c_r.cls][IDX_W-1:0];
        pv_wd = {1'b0, c_r.idx};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= '0;
      for (int i = 0; i < MAX_CLASSES; i++) heads_r[i] <= NIL_LINK;
    end else begin
      case (state_r)
        S_IDLE: if (cmd_valid) begin
          c_r    <= cmd;
          st_r   <= ST_OK;
          gidx_r <= '0;
          gsize_r <= '0;
          p_r    <= {1'b0, cmd.idx};
          get_unlink_r <= 1'b0;
          case (cmd.op)
            OP_ADD:    state_r <= free_r[cmd.idx] ? S_RD_SLOT : S_PUSH_A;
            OP_REMOVE: begin
              if (free_r[cmd.idx]) state_r <= S_RD_SLOT;
              else begin
                st_r <= ST_NOTFREE;
                state_r <= S_DONE;
              end
            end
            OP_GET: begin
              gc_r <= {1'b0, cmd.cls};
              state_r <= S_GET_HEAD;
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_RD_SLOT: state_r <= S_UNLINK_C;   // read data lands
        S_UNLINK_C: begin
          nx_r <= nx_rd;
          pv_r <= pv_rd;
          state_r <= S_UNLINK_A;
        end
        S_UNLINK_A: begin
          for (int i = 0; i < MAX_CLASSES; i++)
            if (heads_r[i] == p_r) heads_r[i] <= nx_r;
          free_r[p_r[IDX_W-1:0]] <= 1'b0;
          state_r <= S_UNLINK_B;
        end
        S_UNLINK_B: begin
          if (c_r.op == OP_ADD && !get_unlink_r) state_r <= S_PUSH_A;
          else state_r <= S_DONE;
        end
        S_PUSH_A: state_r <= S_PUSH_B;
        S_PUSH_B: begin
          heads_r[c_r.cls] <= {1'b0, c_r.idx};
          free_r[c_r.idx] <= 1'b1;
          state_r <= S_DONE;
        end
        S_GET_HEAD: begin
          if (gc_r >= c_r.ncls) begin
            st_r <= ST_NO_FIT;
            state_r <= S_DONE;
          end else begin
            p_r <= heads_r[gc_r[CLS_W-1:0]];
            steps_r <= '0;
            state_r <= (heads_r[gc_r[CLS_W-1:0]] == NIL_LINK) ? S_GET_HEAD : S_GET_RD;
            if (heads_r[gc_r[CLS_W-1:0]] == NIL_LINK) gc_r <= gc_r + 1'b1;
          end
        end
        S_GET_RD: state_r <= S_GET_CHK;
        S_GET_CHK: begin
          if (sz_rd >= c_r.size) begin
            gidx_r  <= p_r[IDX_W-1:0];
            gsize_r <= sz_rd;
            nx_r <= nx_rd;
            pv_r <= pv_rd;
            get_unlink_r <= 1'b1;
            state_r <= S_UNLINK_A;
          end else if (nx_rd == NIL_LINK ||
                       steps_r == (IDX_W+1)'(NUM_DESC - 1)) begin
            gc_r <= gc_r + 1'b1;
            state_r <= S_GET_HEAD;
          end else begin
            p_r <= nx_rd;
            steps_r <= steps_r + 1'b1;
            state_r <= S_GET_RD;
          end
        end
        S_DONE: if (out_ready) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/segregated_free_list_pool_top.sv
// ----------------------------------------------------------------------------
// segregated_free_list_pool_top
// Size-class free-list pool of 64 block descriptors with add/remove/get.
// ----------------------------------------------------------------------------
// One command at a time is executed. A front stage classifies one beat and
// queues up to two more behind it; a beat passes the classification register
// and the command queue before the back end sees it. An add runs PUSH_A,
// PUSH_B and DONE, first unlinking via RD_SLOT, UNLINK_C, UNLINK_A and UNLINK_B
// when the slot was already free; a remove takes that unlink path to DONE. A
// get visits GET_HEAD per class, GET_RD and GET_CHK per list entry examined,
// UNLINK_A and UNLINK_B to unlink a grant, then DONE. Each walk step is one
// registered read of the link and size RAMs. The result is held until taken.
module segregated_free_list_pool_top (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  sfl_pkg::in_item_t     in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output sfl_pkg::out_item_t    out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_index,
  input  logic [15:0]           cfg_data
);
  import sfl_pkg::*;

  logic [LIMIT_W-1:0] limit_r;
  logic [CCNT_W-1:0]  ccnt_r;
  logic  cmd_valid, cmd_ready;
  cmd_t  cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(16);
      ccnt_r  <= CCNT_W'(4);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FIRST_LIMIT: limit_r <= cfg_data;
        CFG_CLASS_COUNT: ccnt_r  <= cfg_data[CCNT_W-1:0];
        default: ;
      endcase
    end
  end

  sfl_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .first_limit(limit_r), .class_count(ccnt_r),
    .cmd_valid, .cmd_ready, .cmd);

  sfl_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_valid, .out_ready, .out_data);

endmodule
